// ----- rtl/pinhole_camera_ray_generator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Pinhole camera ray generator assertion macros
// Shorthand for clocked assertions sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_CAMERA_RAY_GENERATOR_CORE_DEFINES_SVH
`define PINHOLE_CAMERA_RAY_GENERATOR_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCRG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pcrg_pkg.sv -----
// ----------------------------------------------------------------------------
// pcrg_pkg
// Shared constants, codes and types of the pinhole camera ray generator.
// ----------------------------------------------------------------------------
package pcrg_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 18;
    localparam int COMP_BITS     = FRAC_BITS + 3;
    localparam int DIR_BITS      = FRAC_BITS + 2;
    localparam int VEC_BITS      = 3 * COMP_BITS;
    localparam int RATIO_BITS    = 20;
    localparam int RECIP_BITS    = 25;
    localparam int SEED_BITS     = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = VEC_BITS;

    // pixel coordinate scaling into Q.16 with the factor of two folded in
    localparam int PIX_SHIFT     = 17;
    localparam int JIT_BITS      = 17;
    localparam int TX_BITS       = COORD_BITS + PIX_SHIFT + 2;
    localparam int MUL_A_BITS    = 41;
    localparam int MUL_B_BITS    = 31;
    localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
    localparam int A1_BITS       = 41;
    localparam int SCALE_BITS    = 33;
    localparam int FWD_SHIFT     = 25;
    localparam int D_BITS        = 54;
    localparam int NORM_BITS     = 30;
    localparam int ROOT_BITS     = 64;
    localparam int LEN_BITS      = 32;
    localparam int Q_BITS        = FRAC_BITS + 1;
    localparam int NUM_BITS      = NORM_BITS + FRAC_BITS + 1;
    localparam int STEP_BITS     = 5;

    localparam int DIR_STEPS     = 6;
    localparam int SQ_STEPS      = 3;
    localparam int ROOT_STEPS    = 32;

    localparam logic [23:0]          LCG_MUL_LO  = 24'hECE66D;
    localparam logic [10:0]          LCG_MUL_HI  = 11'h5DE;
    localparam logic [SEED_BITS-1:0] LCG_ADD     = 48'hB;
    localparam logic [SEED_BITS-1:0] SEED_RESET  = 48'd20017429951246;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 20'd65536;
    localparam logic [RECIP_BITS-1:0] RECIP_RESET = 25'd16384;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_POSITION,
        REG_FORWARD,
        REG_RIGHT,
        REG_UP,
        REG_RATIO,
        REG_WIDTH_RECIP,
        REG_HEIGHT_RECIP,
        REG_SEED
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RNG_MUL,
        ST_RNG_ADD,
        ST_SCALE_A1,
        ST_SCALE_A,
        ST_SCALE_B,
        ST_DIR,
        ST_ABS,
        ST_MAX,
        ST_NORM,
        ST_SQUARE,
        ST_ROOT,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RNG_MUL,
        OP_RNG_ADD,
        OP_SCALE_A1,
        OP_SCALE_A,
        OP_SCALE_B,
        OP_DIR,
        OP_ABS,
        OP_MAX,
        OP_NORM,
        OP_SQUARE,
        OP_ROOT,
        OP_DIV_INIT,
        OP_DIV,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [STEP_BITS-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic norm_done;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [VEC_BITS-1:0]   position;
        logic [VEC_BITS-1:0]   forward;
        logic [VEC_BITS-1:0]   right;
        logic [VEC_BITS-1:0]   up;
        logic [RATIO_BITS-1:0] ratio;
        logic [RECIP_BITS-1:0] width_recip;
        logic [RECIP_BITS-1:0] height_recip;
    } cfg_t;

endpackage

// ----- rtl/pcrg_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcrg_ctrl
// Sequencer: walks the datapath through one ray, one operation per cycle.
// ----------------------------------------------------------------------------
module pcrg_ctrl import pcrg_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    use_jitter,
    input  status_t status,
    output cmd_t    cmd
);

    state_t               state_reg;
    state_t               state_next;
    logic [STEP_BITS-1:0] cnt_reg;
    logic [STEP_BITS-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + STEP_BITS'(1);
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = use_jitter ? ST_RNG_MUL : ST_SCALE_A1;
            end
            ST_RNG_MUL:
            begin
                cnt_next   = cnt_reg;
                state_next = ST_RNG_ADD;
            end
            ST_RNG_ADD:
            begin
                // first pass draws the x offset, second the y offset
                if (cnt_reg == '0)
                    state_next = ST_RNG_MUL;
                else
                begin
                    state_next = ST_SCALE_A1;
                    cnt_next   = '0;
                end
            end
            ST_SCALE_A1: state_next = ST_SCALE_A;
            ST_SCALE_A:  state_next = ST_SCALE_B;
            ST_SCALE_B:
            begin
                state_next = ST_DIR;
                cnt_next   = '0;
            end
            ST_DIR:
            begin
                if (cnt_reg == STEP_BITS'(DIR_STEPS - 1))
                begin
                    state_next = ST_ABS;
                    cnt_next   = '0;
                end
            end
            ST_ABS: state_next = ST_MAX;
            ST_MAX: state_next = ST_NORM;
            ST_NORM:
            begin
                cnt_next = '0;
                if (status.zero)
                    state_next = ST_FINISH;
                else if (status.norm_done)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                if (cnt_reg == STEP_BITS'(SQ_STEPS - 1))
                begin
                    state_next = ST_ROOT;
                    cnt_next   = '0;
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == STEP_BITS'(ROOT_STEPS - 1))
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                if (cnt_reg == STEP_BITS'(Q_BITS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cnt_next = '0;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.step = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            ST_RNG_MUL:  cmd.op = OP_RNG_MUL;
            ST_RNG_ADD:  cmd.op = OP_RNG_ADD;
            ST_SCALE_A1: cmd.op = OP_SCALE_A1;
            ST_SCALE_A:  cmd.op = OP_SCALE_A;
            ST_SCALE_B:  cmd.op = OP_SCALE_B;
            ST_DIR:      cmd.op = OP_DIR;
            ST_ABS:      cmd.op = OP_ABS;
            ST_MAX:      cmd.op = OP_MAX;
            ST_NORM:     cmd.op = OP_NORM;
            ST_SQUARE:   cmd.op = OP_SQUARE;
            ST_ROOT:     cmd.op = OP_ROOT;
            ST_DIV_INIT: cmd.op = OP_DIV_INIT;
            ST_DIV:      cmd.op = OP_DIV;
            ST_FINISH:   cmd.op = OP_FINISH;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/pcrg_dp.sv -----
// ----------------------------------------------------------------------------
// pcrg_dp
// Datapath: jitter generator, shared multiplier, normaliser, bitwise square
// root, three restoring dividers and the result register.
// ----------------------------------------------------------------------------
module pcrg_dp import pcrg_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    output status_t                     status,
    input  cfg_t                        cfg,
    input  logic                        seed_load,
    input  logic [SEED_BITS-1:0]        seed_value,
    input  logic [COORD_BITS-1:0]       pixel_x,
    input  logic [COORD_BITS-1:0]       pixel_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [VEC_BITS-1:0]         origin_packed,
    output logic signed [DIR_BITS-1:0]  dir_x,
    output logic signed [DIR_BITS-1:0]  dir_y,
    output logic signed [DIR_BITS-1:0]  dir_z
);

    localparam logic signed [PROD_BITS-1:0] ONE_Q40 = PROD_BITS'(1) <<< 40;
    localparam logic signed [PROD_BITS-1:0] SAT_POS = PROD_BITS'(64'sd2147483648);
    localparam logic signed [PROD_BITS-1:0] SAT_NEG = -SAT_POS;

    function automatic logic signed [COMP_BITS-1:0] comp(input logic [VEC_BITS-1:0] v,
                                                         input logic [1:0] k);
        case (k)
            2'd0:    return v[0 +: COMP_BITS];
            2'd1:    return v[COMP_BITS +: COMP_BITS];
            default: return v[2*COMP_BITS +: COMP_BITS];
        endcase
    endfunction

    function automatic logic signed [SCALE_BITS-1:0] sat(input logic signed [PROD_BITS-1:0] v);
        if (v > SAT_POS)
            return SCALE_BITS'(SAT_POS);
        if (v < SAT_NEG)
            return SCALE_BITS'(SAT_NEG);
        return SCALE_BITS'(v);
    endfunction

    logic [SEED_BITS-1:0]          rng_reg, rng_next;
    logic [SEED_BITS-1:0]          rng_lo_reg, rng_lo_next;
    logic [23:0]                   rng_mid_reg, rng_mid_next;
    logic signed [TX_BITS-1:0]     tx_reg, tx_next, ty_reg, ty_next;
    logic signed [A1_BITS-1:0]     a1_reg, a1_next;
    logic signed [SCALE_BITS-1:0]  a_reg, a_next, b_reg, b_next;
    logic signed [D_BITS-1:0]      d_reg [0:2];
    logic signed [D_BITS-1:0]      d_next [0:2];
    logic [D_BITS-1:0]             mag_reg [0:2];
    logic [D_BITS-1:0]             mag_next [0:2];
    logic [D_BITS-1:0]             mx_reg, mx_next;
    logic [ROOT_BITS-1:0]          rs_reg, rs_next, res_reg, res_next, bit_reg, bit_next;
    logic [LEN_BITS-1:0]           rem_reg [0:2];
    logic [LEN_BITS-1:0]           rem_next [0:2];
    logic [Q_BITS-1:0]             nlo_reg [0:2];
    logic [Q_BITS-1:0]             nlo_next [0:2];
    logic [Q_BITS-1:0]             q_reg [0:2];
    logic [Q_BITS-1:0]             q_next [0:2];
    logic                          out_valid_reg, out_valid_next;
    logic [VEC_BITS-1:0]           origin_reg, origin_next;
    logic [DIR_BITS-1:0]           dir_reg [0:2];
    logic [DIR_BITS-1:0]           dir_next [0:2];

    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   product;
    logic signed [PROD_BITS-1:0]   diff;
    logic [SEED_BITS-1:0]          rng_new;
    logic signed [JIT_BITS-1:0]    jit;
    logic [1:0]                    lane;
    logic [ROOT_BITS-1:0]          trial;
    logic [LEN_BITS-1:0]           len;
    logic [NUM_BITS-1:0]           num;
    logic [LEN_BITS:0]             part;
    logic [DIR_BITS-1:0]           q_ext;
    logic                          out_free;
    logic                          zero;
    logic                          norm_done;

    assign out_free  = !out_valid_reg || out_ready;
    assign zero      = (mx_reg == '0);
    assign norm_done = (mx_reg[D_BITS-1:NORM_BITS] == '0) && mx_reg[NORM_BITS-1];
    assign len       = res_reg[LEN_BITS-1:0];

    assign status.zero      = zero;
    assign status.norm_done = norm_done;
    assign status.out_free  = out_free;

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        lane  = (cmd.op == OP_DIR) ? cmd.step[2:1] : cmd.step[1:0];
        case (cmd.op)
            OP_SCALE_A1:
            begin
                mul_a = MUL_A_BITS'(tx_reg);
                mul_b = {{(MUL_B_BITS-RECIP_BITS){1'b0}}, cfg.width_recip};
            end
            OP_SCALE_A:
            begin
                mul_a = MUL_A_BITS'(a1_reg);
                mul_b = {{(MUL_B_BITS-RATIO_BITS){1'b0}}, cfg.ratio};
            end
            OP_SCALE_B:
            begin
                mul_a = MUL_A_BITS'(ty_reg);
                mul_b = {{(MUL_B_BITS-RECIP_BITS){1'b0}}, cfg.height_recip};
            end
            OP_DIR:
            begin
                if (cmd.step[0])
                begin
                    mul_a = MUL_A_BITS'(b_reg);
                    mul_b = MUL_B_BITS'(comp(cfg.up, lane));
                end
                else
                begin
                    mul_a = MUL_A_BITS'(a_reg);
                    mul_b = MUL_B_BITS'(comp(cfg.right, lane));
                end
            end
            OP_SQUARE:
            begin
                mul_a = {{(MUL_A_BITS-NORM_BITS){1'b0}}, mag_reg[lane][NORM_BITS-1:0]};
                mul_b = {{(MUL_B_BITS-NORM_BITS){1'b0}}, mag_reg[lane][NORM_BITS-1:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = mul_a * mul_b;
    end

    always_comb
    begin
        rng_next       = rng_reg;
        rng_lo_next    = rng_lo_reg;
        rng_mid_next   = rng_mid_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        a1_next        = a1_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        mx_next        = mx_reg;
        rs_next        = rs_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        origin_next    = origin_reg;
        diff           = '0;
        trial          = res_reg + bit_reg;
        num            = '0;
        part           = '0;
        q_ext          = '0;
        rng_new        = rng_lo_reg + {rng_mid_reg, 24'b0} + LCG_ADD;
        jit            = {~rng_new[SEED_BITS-1], rng_new[SEED_BITS-2:SEED_BITS-JIT_BITS]};
        for (int i = 0; i < 3; i++)
        begin
            d_next[i]   = d_reg[i];
            mag_next[i] = mag_reg[i];
            rem_next[i] = rem_reg[i];
            nlo_next[i] = nlo_reg[i];
            q_next[i]   = q_reg[i];
            dir_next[i] = dir_reg[i];
        end

        if (out_ready)
            out_valid_next = 1'b0;

        case (cmd.op)
            OP_LOAD:
            begin
                tx_next = TX_BITS'({pixel_x, {PIX_SHIFT{1'b0}}});
                ty_next = TX_BITS'({pixel_y, {PIX_SHIFT{1'b0}}});
            end
            OP_RNG_MUL:
            begin
                // state * multiplier mod 2^48, split at bit 24
                rng_lo_next  = {24'b0, rng_reg[23:0]} * {24'b0, LCG_MUL_LO};
                rng_mid_next = rng_reg[47:24] * LCG_MUL_LO
                             + rng_reg[23:0] * {13'b0, LCG_MUL_HI};
            end
            OP_RNG_ADD:
            begin
                rng_next = rng_new;
                if (cmd.step == '0)
                    tx_next = tx_reg + TX_BITS'(jit);
                else
                    ty_next = ty_reg + TX_BITS'(jit);
            end
            OP_SCALE_A1:
            begin
                diff    = product - ONE_Q40;
                a1_next = A1_BITS'(diff >>> 16);
            end
            OP_SCALE_A:
            begin
                diff   = product >>> 16;
                a_next = sat(diff);
            end
            OP_SCALE_B:
            begin
                diff   = ONE_Q40 - product;
                b_next = sat(diff >>> 16);
            end
            OP_DIR:
            begin
                if (cmd.step[0])
                    d_next[lane] = d_reg[lane] + D_BITS'(product);
                else
                    d_next[lane] = (D_BITS'(comp(cfg.forward, lane)) <<< FWD_SHIFT)
                                 + D_BITS'(product);
            end
            OP_ABS:
            begin
                for (int i = 0; i < 3; i++)
                    mag_next[i] = d_reg[i][D_BITS-1] ? D_BITS'(-d_reg[i]) : D_BITS'(d_reg[i]);
            end
            OP_MAX:
            begin
                mx_next = mag_reg[0];
                if (mag_reg[1] > mx_next)
                    mx_next = mag_reg[1];
                if (mag_reg[2] > mx_next)
                    mx_next = mag_reg[2];
            end
            OP_NORM:
            begin
                if (mx_reg[D_BITS-1:NORM_BITS] != '0)
                begin
                    mx_next = mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if (!norm_done && !zero)
                begin
                    mx_next = mx_reg << 1;
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
            end
            OP_SQUARE:
            begin
                rs_next  = ((cmd.step == '0) ? '0 : rs_reg) + ROOT_BITS'(product);
                res_next = '0;
                bit_next = ROOT_BITS'(1) << (ROOT_BITS - 2);
            end
            OP_ROOT:
            begin
                if (rs_reg >= trial)
                begin
                    rs_next  = rs_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                    res_next = res_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            OP_DIV_INIT:
            begin
                // numerator (mag << FRAC_BITS) + len/2; quotient is at most 2^FRAC_BITS
                for (int i = 0; i < 3; i++)
                begin
                    num = {1'b0, mag_reg[i][NORM_BITS-1:0], {FRAC_BITS{1'b0}}}
                        + NUM_BITS'(len >> 1);
                    rem_next[i] = LEN_BITS'(num[NUM_BITS-1:Q_BITS]);
                    nlo_next[i] = num[Q_BITS-1:0];
                    q_next[i]   = '0;
                end
            end
            OP_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    part = {rem_reg[i], nlo_reg[i][Q_BITS-1]};
                    if (part >= {1'b0, len})
                    begin
                        rem_next[i] = LEN_BITS'(part - {1'b0, len});
                        q_next[i]   = {q_reg[i][Q_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = LEN_BITS'(part);
                        q_next[i]   = {q_reg[i][Q_BITS-2:0], 1'b0};
                    end
                    nlo_next[i] = nlo_reg[i] << 1;
                end
            end
            OP_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    origin_next    = cfg.position;
                    for (int i = 0; i < 3; i++)
                    begin
                        q_ext = DIR_BITS'(q_reg[i]);
                        if (zero)
                            dir_next[i] = '0;
                        else if (d_reg[i][D_BITS-1])
                            dir_next[i] = '0 - q_ext;
                        else
                            dir_next[i] = q_ext;
                    end
                end
            end
            default:
            begin
                rng_next = rng_reg;
            end
        endcase

        if (seed_load)
            rng_next = seed_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg       <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rng_reg       <= rng_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rng_lo_reg  <= rng_lo_next;
        rng_mid_reg <= rng_mid_next;
        tx_reg      <= tx_next;
        ty_reg      <= ty_next;
        a1_reg      <= a1_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        mx_reg      <= mx_next;
        rs_reg      <= rs_next;
        res_reg     <= res_next;
        bit_reg     <= bit_next;
        origin_reg  <= origin_next;
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i]   <= d_next[i];
            mag_reg[i] <= mag_next[i];
            rem_reg[i] <= rem_next[i];
            nlo_reg[i] <= nlo_next[i];
            q_reg[i]   <= q_next[i];
            dir_reg[i] <= dir_next[i];
        end
    end

    assign out_valid     = out_valid_reg;
    assign origin_packed = origin_reg;
    assign dir_x         = dir_reg[0];
    assign dir_y         = dir_reg[1];
    assign dir_z         = dir_reg[2];

endmodule

// ----- rtl/pinhole_camera_ray_generator_core.sv -----
// ----------------------------------------------------------------------------
// pinhole_camera_ray_generator_core
// Primary ray generator for a pinhole camera: pixel in, unit ray out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes pixel_x, pixel_y and use_jitter.
// Output channel (out_valid/out_ready) gives the ray origin and the unit
// direction dir_x/dir_y/dir_z in signed Q1.18.
// Configuration channel (cfg_valid/cfg_ready) writes camera registers by
// index; it is always ready. Writing the seed register reloads the jitter
// generator. Write registers only while no ray is in flight.
// One ray is worked on at a time. The direction uses a single shared
// multiplier over nine passes, normalisation shifts one bit a cycle, the
// square root resolves one bit a cycle for its 32 result bits and the
// dividers one quotient bit a cycle for their 19-bit quotients. An
// all-zero direction skips the root and divide. A finished ray sits in
// the output register while the next pixel is accepted; if the receiver
// stalls, the next ray waits in its last step until the register is free.
// Reset clears the pipeline and loads the register reset values and the
// default seed.
// ----------------------------------------------------------------------------
`include "pinhole_camera_ray_generator_core_defines.svh"

module pinhole_camera_ray_generator_core import pcrg_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_BITS-1:0]       pixel_x,
    input  logic [COORD_BITS-1:0]       pixel_y,
    input  logic                        use_jitter,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [VEC_BITS-1:0]         origin_packed,
    output logic signed [DIR_BITS-1:0]  dir_x,
    output logic signed [DIR_BITS-1:0]  dir_y,
    output logic signed [DIR_BITS-1:0]  dir_z,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    cmd_t    cmd;
    status_t status;
    logic    seed_load;

    assign cfg_ready = 1'b1;
    assign seed_load = cfg_valid && (cfg_reg_t'(cfg_index) == REG_SEED);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POSITION:     cfg_next.position     = cfg_data;
                REG_FORWARD:      cfg_next.forward      = cfg_data;
                REG_RIGHT:        cfg_next.right        = cfg_data;
                REG_UP:           cfg_next.up           = cfg_data;
                REG_RATIO:        cfg_next.ratio        = cfg_data[RATIO_BITS-1:0];
                REG_WIDTH_RECIP:  cfg_next.width_recip  = cfg_data[RECIP_BITS-1:0];
                REG_HEIGHT_RECIP: cfg_next.height_recip = cfg_data[RECIP_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position     <= '0;
            cfg_reg.forward      <= '0;
            cfg_reg.right        <= '0;
            cfg_reg.up           <= '0;
            cfg_reg.ratio        <= RATIO_RESET;
            cfg_reg.width_recip  <= RECIP_RESET;
            cfg_reg.height_recip <= RECIP_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    pcrg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .use_jitter (use_jitter),
        .status     (status),
        .cmd        (cmd)
    );

    pcrg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg_reg),
        .seed_load     (seed_load),
        .seed_value    (cfg_data[SEED_BITS-1:0]),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .origin_packed (origin_packed),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z)
    );

    `PCRG_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready, "second transaction taken while a ray is in flight")
    `PCRG_ASSERT_SAME(a_result_from_finish, $rose(out_valid), $past(cmd.op == OP_FINISH), "result appeared outside the finish step")
    `PCRG_ASSERT_SAME(a_unit_range, out_valid, (dir_x <= 20'sd262144) && (dir_x >= -20'sd262144) && (dir_y <= 20'sd262144) && (dir_y >= -20'sd262144) && (dir_z <= 20'sd262144) && (dir_z >= -20'sd262144), "direction component beyond unit length")

endmodule

// ----- bench/pinhole_camera_ray_generator_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pinhole_camera_ray_generator_core_test
// Drives pixels through the ray generator under random flow control. A
// directed table covers reset values, extremes and saturation. Random
// phases then run under a series of camera settings. Every ray is checked
// against its typed expectation or the local fixed-point camera model.
// ----------------------------------------------------------------------------
module pinhole_camera_ray_generator_core_test;
    import pcrg_pkg::*;

    typedef struct {
        logic [VEC_BITS-1:0]        origin;
        logic signed [DIR_BITS-1:0] dx;
        logic signed [DIR_BITS-1:0] dy;
        logic signed [DIR_BITS-1:0] dz;
    } ray_t;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  jit;
        logic                  typed;
        ray_t                  ray;
    } pixel_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [COORD_BITS-1:0]      pixel_x = '0;
    logic [COORD_BITS-1:0]      pixel_y = '0;
    logic                       use_jitter = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [VEC_BITS-1:0]        origin_packed;
    logic signed [DIR_BITS-1:0] dir_x;
    logic signed [DIR_BITS-1:0] dir_y;
    logic signed [DIR_BITS-1:0] dir_z;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_reg_t                   cfg_index = REG_POSITION;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

    // camera copy held by the model
    logic [63:0] cam_reg [8];
    logic [47:0] jitter_state;
    ray_t        pending_rays [$];
    int          errors = 0;
    bit          calm = 1'b0;

    pinhole_camera_ray_generator_core DUT (.*);

    always #5 clk = ~clk;

    function automatic logic [VEC_BITS-1:0] pack_vec(int cx, int cy, int cz);
        logic [COMP_BITS-1:0] a, b, c;
        a = COMP_BITS'(cx);
        b = COMP_BITS'(cy);
        c = COMP_BITS'(cz);
        return {c, b, a};
    endfunction

    function automatic longint vec_part(logic [63:0] v, int k);
        logic signed [COMP_BITS-1:0] f;
        f = v[k*COMP_BITS +: COMP_BITS];
        return longint'(f);
    endfunction

    function automatic longint jitter_draw();
        logic [63:0] p;
        p = 64'h5DEECE66D * {16'd0, jitter_state} + 64'hB;
        jitter_state = p[47:0];
        return longint'({16'd0, jitter_state} >> 31) - 65536;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (s >= res + bitv)
            begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp_scale(longint v);
        if (v > 64'sd2147483648)
            return 64'sd2147483648;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic ray_t predict_ray(logic [COORD_BITS-1:0] x,
                                         logic [COORD_BITS-1:0] y, logic jit);
        ray_t            r;
        longint          jx, jy, tx, ty, a, b;
        longint          d [3];
        longint unsigned mag [3];
        longint unsigned mx, s, len, q, v;
        jx = 0;
        jy = 0;
        if (jit)
        begin
            jx = jitter_draw();
            jy = jitter_draw();
        end
        tx = longint'(x) * 131072 + jx;
        ty = longint'(y) * 131072 + jy;
        a = (tx * longint'(cam_reg[REG_WIDTH_RECIP]) - (64'sd1 << 40)) >>> 16;
        a = clamp_scale((a * longint'(cam_reg[REG_RATIO])) >>> 16);
        b = clamp_scale(((64'sd1 << 40) - ty * longint'(cam_reg[REG_HEIGHT_RECIP])) >>> 16);
        mx = 0;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = vec_part(cam_reg[REG_FORWARD], k) * 2 * 16777216
                 + vec_part(cam_reg[REG_RIGHT], k) * a + vec_part(cam_reg[REG_UP], k) * b;
            mag[k] = d[k] < 0 ? -d[k] : d[k];
            if (mag[k] > mx)
                mx = mag[k];
        end
        r.origin = cam_reg[REG_POSITION][VEC_BITS-1:0];
        r.dx = '0;
        r.dy = '0;
        r.dz = '0;
        if (mx == 0)
            return r;
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int k = 0; k < 3; k++)
                mag[k] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int k = 0; k < 3; k++)
                mag[k] <<= 1;
        end
        s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = isqrt64(s);
        for (int k = 0; k < 3; k++)
        begin
            q = ((mag[k] << FRAC_BITS) + (len >> 1)) / len;
            v = d[k] < 0 ? -q : q;
            if (k == 0) r.dx = v[DIR_BITS-1:0];
            if (k == 1) r.dy = v[DIR_BITS-1:0];
            if (k == 2) r.dz = v[DIR_BITS-1:0];
        end
        return r;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 34);
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        int w;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RATIO:                        w = RATIO_BITS;
            REG_WIDTH_RECIP, REG_HEIGHT_RECIP: w = RECIP_BITS;
            REG_SEED:                         w = SEED_BITS;
            default:                          w = VEC_BITS;
        endcase
        cam_reg[idx] = val & ((64'd1 << w) - 1);
        if (idx == REG_SEED)
            jitter_state = cam_reg[REG_SEED][47:0];
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_rays.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // typed expectation takes precedence; the model still runs to keep the
    // jitter generator in step
    task automatic send_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                              logic jit, logic typed, ray_t ray);
        ray_t r;
        if (idle_now())
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel_x    <= x;
        pixel_y    <= y;
        use_jitter <= jit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_ray(x, y, jit);
        pending_rays.push_back(typed ? ray : r);
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        ray_t e;
        if (rst_n)
            out_ready <= !idle_now();
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rays.size() == 0)
            begin
                $display("%0t: unexpected ray, origin %h dir %0d %0d %0d",
                         $time, origin_packed, dir_x, dir_y, dir_z);
                errors++;
            end
            else
            begin
                e = pending_rays.pop_front();
                if (origin_packed !== e.origin)
                begin
                    $display("%0t: origin expected %h actual %h", $time, e.origin, origin_packed);
                    errors++;
                end
                if (dir_x !== e.dx)
                begin
                    $display("%0t: dir_x expected %0d actual %0d", $time, e.dx, dir_x);
                    errors++;
                end
                if (dir_y !== e.dy)
                begin
                    $display("%0t: dir_y expected %0d actual %0d", $time, e.dy, dir_y);
                    errors++;
                end
                if (dir_z !== e.dz)
                begin
                    $display("%0t: dir_z expected %0d actual %0d", $time, e.dz, dir_z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        pixel_row_t  rows [$];
        pixel_row_t  row;
        ray_t        zero_ray, fwd_ray;
        logic [63:0] seed_val;
        zero_ray = '{origin: '0, dx: '0, dy: '0, dz: '0};
        fwd_ray  = '{origin: pack_vec(1, -1, 5), dx: 20'sd262144, dy: '0, dz: '0};
        for (int i = 0; i < 8; i++)
            cam_reg[i] = 0;
        cam_reg[REG_RATIO]        = RATIO_RESET;
        cam_reg[REG_WIDTH_RECIP]  = RECIP_RESET;
        cam_reg[REG_HEIGHT_RECIP] = RECIP_RESET;
        cam_reg[REG_SEED]         = SEED_RESET;
        jitter_state              = SEED_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset camera: all vectors zero, so every direction is zero
        rows = '{
            '{0, 0, 0, 1, zero_ray},
            '{4095, 4095, 1, 1, zero_ray},
            '{0, 4095, 1, 1, zero_ray},
            '{4095, 0, 0, 1, zero_ray}
        };
        foreach (rows[i])
            send_pixel(rows[i].x, rows[i].y, rows[i].jit, rows[i].typed, rows[i].ray);
        release_input();
        drain();

        // forward only: direction is exactly +x whatever the pixel
        write_reg(REG_POSITION, pack_vec(1, -1, 5));
        write_reg(REG_FORWARD, pack_vec(262144, 0, 0));
        rows = '{
            '{0, 0, 0, 1, fwd_ray},
            '{4095, 4095, 0, 1, fwd_ray},
            '{2048, 17, 0, 1, fwd_ray}
        };
        foreach (rows[i])
            send_pixel(rows[i].x, rows[i].y, rows[i].jit, rows[i].typed, rows[i].ray);
        release_input();
        drain();

        // ordinary camera looking down -z, then extreme reciprocals to saturate
        write_reg(REG_FORWARD, pack_vec(0, 0, -262144));
        write_reg(REG_RIGHT, pack_vec(262144, 0, 0));
        write_reg(REG_UP, pack_vec(0, 262144, 0));
        write_reg(REG_RATIO, 20'd87381);
        write_reg(REG_WIDTH_RECIP, 25'd262144);
        write_reg(REG_HEIGHT_RECIP, 25'd262144);
        write_reg(REG_SEED, 48'd12345);
        rows = '{
            '{0, 0, 0, 0, zero_ray},
            '{32, 32, 0, 0, zero_ray},
            '{63, 63, 1, 0, zero_ray},
            '{4095, 4095, 1, 0, zero_ray},
            '{0, 4095, 1, 0, zero_ray},
            '{4095, 0, 0, 0, zero_ray},
            '{31, 32, 1, 0, zero_ray}
        };
        foreach (rows[i])
            send_pixel(rows[i].x, rows[i].y, rows[i].jit, rows[i].typed, rows[i].ray);
        release_input();
        drain();
        write_reg(REG_WIDTH_RECIP, 25'd16777216);
        write_reg(REG_HEIGHT_RECIP, 25'd16777216);
        write_reg(REG_RATIO, 20'hFFFFF);
        rows = '{
            '{4095, 4095, 1, 0, zero_ray},
            '{0, 0, 1, 0, zero_ray},
            '{4095, 0, 0, 0, zero_ray},
            '{1, 1, 0, 0, zero_ray}
        };
        foreach (rows[i])
            send_pixel(rows[i].x, rows[i].y, rows[i].jit, rows[i].typed, rows[i].ray);
        release_input();
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            calm = (ph == 3);
            seed_val = {$urandom, $urandom};
            case (ph)
                1:
                begin
                    for (int k = 0; k < 4; k++)
                        write_reg(cfg_reg_t'(k), 64'h7FFF_FFFF_FFFF_FFFF);
                    write_reg(REG_RATIO, 20'hFFFFF);
                    write_reg(REG_WIDTH_RECIP, 25'h1FF_FFFF);
                    write_reg(REG_HEIGHT_RECIP, 25'h1FF_FFFF);
                    write_reg(REG_SEED, 48'hFFFF_FFFF_FFFF);
                end
                2:
                begin
                    write_reg(REG_FORWARD, pack_vec(-1048576, -1048576, -1048576));
                    write_reg(REG_RIGHT, pack_vec(1048575, -1048576, 0));
                    write_reg(REG_UP, pack_vec(0, 1048575, -1048576));
                    write_reg(REG_RATIO, 20'd0);
                    write_reg(REG_WIDTH_RECIP, 25'd0);
                    write_reg(REG_HEIGHT_RECIP, 25'd0);
                    write_reg(REG_SEED, 48'd0);
                end
                3, 4:
                begin
                    write_reg(REG_FORWARD, pack_vec($urandom_range(524288) - 262144, 0, -262144));
                    write_reg(REG_RIGHT, pack_vec(262144, $urandom_range(4096), 0));
                    write_reg(REG_UP, pack_vec(0, 262144, $urandom_range(4096)));
                    write_reg(REG_RATIO, $urandom_range(65536, 131072));
                    write_reg(REG_WIDTH_RECIP, 25'd16777216 >> $urandom_range(12));
                    write_reg(REG_HEIGHT_RECIP, 25'd16777216 >> $urandom_range(12));
                    write_reg(REG_SEED, seed_val);
                end
                default:
                begin
                    for (int k = 0; k < 4; k++)
                        write_reg(cfg_reg_t'(k), {$urandom, $urandom});
                    write_reg(REG_RATIO, $urandom);
                    write_reg(REG_WIDTH_RECIP, $urandom);
                    write_reg(REG_HEIGHT_RECIP, $urandom);
                    write_reg(REG_SEED, seed_val);
                end
            endcase
            write_reg(REG_POSITION, {$urandom, $urandom});
            for (int n = 0; n < 275; n++)
            begin
                if (ph >= 3 && $urandom_range(3) != 0)
                    send_pixel($urandom_range(4095 >> $urandom_range(6)),
                               $urandom_range(4095 >> $urandom_range(6)),
                               $urandom_range(1), 1'b0, zero_ray);
                else
                    send_pixel($urandom, $urandom, $urandom_range(1), 1'b0, zero_ray);
            end
            release_input();
            drain();
        end

        repeat (150) @(posedge clk);
        if (errors == 0 && pending_rays.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pcrg_pkg.sv
rtl/pcrg_ctrl.sv
rtl/pcrg_dp.sv
rtl/pinhole_camera_ray_generator_core.sv
bench/pinhole_camera_ray_generator_core_test.sv
